>>> sv/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define ASSERT_NEXT_NORST(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("%m: reset check failed");

`endif

>>> sv/wglf_pkg.sv
// Package: widths, codes and defaults of the window gradient / LBP feature unit.
`default_nettype none

package wglf_pkg;

   localparam int PIXEL_IN_WIDTH        = 8;
   localparam int FEATURE_WIDTH         = 17;
   localparam int ROW_WIDTH_BITS        = 11;
   localparam int FRAME_ROWS_BITS       = 13;
   localparam int ROW_COUNT_BITS        = 12;
   localparam int CSR_INDEX_WIDTH       = 2;
   localparam int CSR_DATA_WIDTH        = 13;

   localparam int DEFAULT_MAX_ROW_WIDTH = 1024;
   localparam int DEFAULT_PIXEL_BITS    = 8;

   localparam int MIN_DIM               = 3;
   localparam int ROWS_LIMIT            = 4096;
   localparam int ROW_WIDTH_RESET       = 640;
   localparam int FRAME_ROWS_RESET      = 480;
   localparam int FEATURE_MAX           = 131071;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_FEATURE_MODE = 2'd0,
      CSR_ROW_WIDTH    = 2'd1,
      CSR_FRAME_ROWS   = 2'd2
   } csr_index_type;

   typedef enum logic {
      MODE_GRADIENT = 1'b0,
      MODE_LBP      = 1'b1
   } feature_mode_type;

endpackage

`default_nettype wire

>>> sv/wglf_if.sv
// Valid/ready channel interfaces for pixel requests and feature results.
`default_nettype none

interface wglf_req_if;
   import wglf_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [PIXEL_IN_WIDTH-1:0] pixel_value;

   modport source (output valid, output pixel_value, input ready);
   modport sink   (input valid, input pixel_value, output ready);
endinterface

interface wglf_rsp_if;
   import wglf_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [FEATURE_WIDTH-1:0] feature_value;
   logic                     row_end;
   logic                     frame_end;

   modport source (output valid, output feature_value, output row_end, output frame_end,
                   input ready);
   modport sink   (input valid, input feature_value, input row_end, input frame_end,
                   output ready);
endinterface

`default_nettype wire

>>> sv/window_gradient_lbp_feature_unit.sv
// Top level: 3x3 window feature unit (squared gradient or LBP) over a raster pixel stream.
// Stages from request accept to result valid: line-store read, 3x3 window, feature.
// Throughput: one request per cycle unless output stalls; every stage advances together on one enable.
// One read and one write port per line store set the stage split: read at accept, write from stage 1.
// Reset (synchronous): clears counters, valids and CSRs to mode 0, 640 x 480.
// Line stores are not cleared; no clearing pass, requests are taken right after reset.
`default_nettype none

module window_gradient_lbp_feature_unit #(
   parameter int MAX_ROW_WIDTH = wglf_pkg::DEFAULT_MAX_ROW_WIDTH,
   parameter int PIXEL_BITS    = wglf_pkg::DEFAULT_PIXEL_BITS
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   wglf_req_if.sink                                  req_if,
   wglf_rsp_if.source                                rsp_if,
   input  wire logic                                 csr_we,
   input  wire logic [wglf_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [wglf_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import wglf_pkg::*;

   // column address width, and a compare width that holds both row_width and the max
   localparam int AW   = $clog2(MAX_ROW_WIDTH);
   localparam int WB   = (AW + 1 > ROW_WIDTH_BITS) ? AW + 1 : ROW_WIDTH_BITS;
   localparam int DW   = PIXEL_BITS + 1;        // signed central difference
   localparam int SUMW = 2 * PIXEL_BITS + 1;    // dx^2 + dy^2
   localparam int GW   = (SUMW > FEATURE_WIDTH) ? SUMW : FEATURE_WIDTH;

   // ---------------- CSRs ----------------
   feature_mode_type           mode_ff;
   logic [ROW_WIDTH_BITS-1:0]  row_width_ff;
   logic [FRAME_ROWS_BITS-1:0] frame_rows_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_GRADIENT;
         row_width_ff  <= ROW_WIDTH_BITS'(ROW_WIDTH_RESET);
         frame_rows_ff <= FRAME_ROWS_BITS'(FRAME_ROWS_RESET);
      end else if (csr_we) begin
         case (csr_index)
            CSR_FEATURE_MODE: mode_ff       <= feature_mode_type'(csr_wdata[0]);
            CSR_ROW_WIDTH:    row_width_ff  <= csr_wdata[ROW_WIDTH_BITS-1:0];
            CSR_FRAME_ROWS:   frame_rows_ff <= csr_wdata[FRAME_ROWS_BITS-1:0];
            default: ;       // unmapped index: write dropped
         endcase
      end
   end

   // Effective geometry, clamped to the supported range.
   logic [WB-1:0]              rw_ext;
   logic [WB-1:0]              eff_w;
   logic [FRAME_ROWS_BITS-1:0] eff_h;

   always_comb begin
      rw_ext = WB'(row_width_ff);
      if (rw_ext < WB'(MIN_DIM))
         eff_w = WB'(MIN_DIM);
      else if (rw_ext > WB'(MAX_ROW_WIDTH))
         eff_w = WB'(MAX_ROW_WIDTH);
      else
         eff_w = rw_ext;

      if (frame_rows_ff < FRAME_ROWS_BITS'(MIN_DIM))
         eff_h = FRAME_ROWS_BITS'(MIN_DIM);
      else if (frame_rows_ff > FRAME_ROWS_BITS'(ROWS_LIMIT))
         eff_h = FRAME_ROWS_BITS'(ROWS_LIMIT);
      else
         eff_h = frame_rows_ff;
   end

   // ---------------- pipeline enable ----------------
   // Whole pipe moves when the output register is free or being drained.
   logic rsp_valid_ff;
   logic adv;
   logic req_fire;

   assign adv          = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = adv;
   assign req_fire     = adv && req_if.valid;

   // ---------------- raster position ----------------
   logic [AW-1:0]             col_cnt_ff;
   logic [ROW_COUNT_BITS-1:0] row_cnt_ff;
   logic                      last_col;
   logic                      last_row;
   logic                      emit;
   logic [PIXEL_BITS-1:0]     pix_in;

   assign last_col = WB'(col_cnt_ff) >= (eff_w - WB'(1));
   assign last_row = FRAME_ROWS_BITS'(row_cnt_ff) >= (eff_h - FRAME_ROWS_BITS'(1));
   // interior centre exists once two rows and two columns are behind us
   assign emit     = (row_cnt_ff >= ROW_COUNT_BITS'(2)) && (col_cnt_ff >= AW'(2));
   assign pix_in   = PIXEL_BITS'(req_if.pixel_value);   // bits above PIXEL_BITS dropped

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
      end else if (req_fire) begin
         if (last_col) begin
            col_cnt_ff <= '0;
            row_cnt_ff <= last_row ? '0 : row_cnt_ff + ROW_COUNT_BITS'(1);
         end else begin
            col_cnt_ff <= col_cnt_ff + AW'(1);
         end
      end
   end

   // ---------------- stage 1: line-store read ----------------
   logic [PIXEL_BITS-1:0] upper_mem  [MAX_ROW_WIDTH];
   logic [PIXEL_BITS-1:0] middle_mem [MAX_ROW_WIDTH];
   logic [PIXEL_BITS-1:0] up_rd_ff;
   logic [PIXEL_BITS-1:0] mid_rd_ff;

   logic                  s1_valid_ff;
   logic [AW-1:0]         s1_addr_ff;
   logic [PIXEL_BITS-1:0] s1_pix_ff;
   logic                  s1_emit_ff;
   logic                  s1_row_end_ff;
   logic                  s1_frame_end_ff;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         up_rd_ff  <= upper_mem[col_cnt_ff];
         mid_rd_ff <= middle_mem[col_cnt_ff];
      end
   end

   // Rotate the column: middle moves up, new pixel goes to middle. The same column
   // is read again no sooner than three requests later, so no bypass is needed.
   always_ff @(posedge clock) begin
      if (adv && s1_valid_ff) begin
         upper_mem[s1_addr_ff]  <= mid_rd_ff;
         middle_mem[s1_addr_ff] <= s1_pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         s1_valid_ff <= 1'b0;
      else if (adv)
         s1_valid_ff <= req_if.valid;
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_addr_ff      <= col_cnt_ff;
         s1_pix_ff       <= pix_in;
         s1_emit_ff      <= emit;
         s1_row_end_ff   <= last_col;
         s1_frame_end_ff <= last_col && last_row;
      end
   end

   // ---------------- stage 2: 3x3 window ----------------
   // win_ff[row][col]: row 0 above, col 2 newest.
   logic [PIXEL_BITS-1:0] win_ff [3][3];
   logic                  s2_valid_ff;
   logic                  s2_emit_ff;
   logic                  s2_row_end_ff;
   logic                  s2_frame_end_ff;

   always_ff @(posedge clock) begin
      if (adv && s1_valid_ff) begin
         for (int k = 0; k < 3; k++) begin
            win_ff[k][0] <= win_ff[k][1];
            win_ff[k][1] <= win_ff[k][2];
         end
         win_ff[0][2]    <= up_rd_ff;
         win_ff[1][2]    <= mid_rd_ff;
         win_ff[2][2]    <= s1_pix_ff;
         s2_emit_ff      <= s1_emit_ff;
         s2_row_end_ff   <= s1_row_end_ff;
         s2_frame_end_ff <= s1_frame_end_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         s2_valid_ff <= 1'b0;
      else if (adv)
         s2_valid_ff <= s1_valid_ff;
   end

   // ---------------- stage 3: feature ----------------
   logic signed [DW-1:0]   dx;
   logic signed [DW-1:0]   dy;
   logic [2*DW-1:0]        dx_sq;
   logic [2*DW-1:0]        dy_sq;
   logic [SUMW-1:0]        grad_sum;
   logic [GW-1:0]          grad_ext;
   logic [FEATURE_WIDTH-1:0] grad_feat;
   logic [7:0]             lbp_bits;
   logic [FEATURE_WIDTH-1:0] lbp_feat;
   logic [FEATURE_WIDTH-1:0] feat_in;

   always_comb begin
      dx       = $signed({1'b0, win_ff[1][2]}) - $signed({1'b0, win_ff[1][0]});
      dy       = $signed({1'b0, win_ff[2][1]}) - $signed({1'b0, win_ff[0][1]});
      dx_sq    = (2*DW)'(dx) * (2*DW)'(dx);
      dy_sq    = (2*DW)'(dy) * (2*DW)'(dy);
      grad_sum = SUMW'(dx_sq) + SUMW'(dy_sq);
      grad_ext = GW'(grad_sum);
      // only reachable for pixels wider than 8 bits
      if (grad_ext > GW'(FEATURE_MAX))
         grad_feat = FEATURE_WIDTH'(FEATURE_MAX);
      else
         grad_feat = FEATURE_WIDTH'(grad_ext);

      // NW,N,NE,W,E,SW,S,SE on bits 1..8; set when centre >= neighbour
      lbp_bits[0] = win_ff[1][1] >= win_ff[0][0];
      lbp_bits[1] = win_ff[1][1] >= win_ff[0][1];
      lbp_bits[2] = win_ff[1][1] >= win_ff[0][2];
      lbp_bits[3] = win_ff[1][1] >= win_ff[1][0];
      lbp_bits[4] = win_ff[1][1] >= win_ff[1][2];
      lbp_bits[5] = win_ff[1][1] >= win_ff[2][0];
      lbp_bits[6] = win_ff[1][1] >= win_ff[2][1];
      lbp_bits[7] = win_ff[1][1] >= win_ff[2][2];
      lbp_feat    = FEATURE_WIDTH'({lbp_bits, 1'b0});

      feat_in = (mode_ff == MODE_LBP) ? lbp_feat : grad_feat;
   end

   // ---------------- result register ----------------
   logic [FEATURE_WIDTH-1:0] rsp_feature_ff;
   logic                     rsp_row_end_ff;
   logic                     rsp_frame_end_ff;

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (adv)
         rsp_valid_ff <= s2_valid_ff && s2_emit_ff;   // border pixels give no result
   end

   always_ff @(posedge clock) begin
      if (adv && s2_valid_ff) begin
         rsp_feature_ff   <= feat_in;
         rsp_row_end_ff   <= s2_row_end_ff;
         rsp_frame_end_ff <= s2_frame_end_ff;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.feature_value = rsp_feature_ff;
   assign rsp_if.row_end       = rsp_row_end_ff;
   assign rsp_if.frame_end     = rsp_frame_end_ff;

endmodule

`default_nettype wire

>>> sv/wglf_checker.sv
// Port-level checker for the feature unit, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module wglf_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_valid,
   input wire logic                               req_ready,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ready,
   input wire logic [wglf_pkg::FEATURE_WIDTH-1:0] rsp_feature_value,
   input wire logic                               rsp_row_end,
   input wire logic                               rsp_frame_end
);
   import wglf_pkg::*;

   logic [FEATURE_WIDTH+1:0] rsp_payload;
   assign rsp_payload = {rsp_feature_value, rsp_row_end, rsp_frame_end};

   // empty output register must never block the input side
   `ASSERT_IMPL(a_ready_when_empty, clock, reset, !rsp_valid, req_ready)
   // a request is taken beside a waiting result only while that result drains
   `ASSERT_IMPL(a_accept_drains, clock, reset, req_valid && req_ready && rsp_valid, rsp_ready)
   // frame end is always also a row end
   `ASSERT_IMPL(a_frame_end_row_end, clock, reset, rsp_valid && rsp_frame_end, rsp_row_end)
   // a stalled result holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                rsp_valid && $stable(rsp_payload))
   // reset empties the pipe
   `ASSERT_NEXT_NORST(a_reset_empty, clock, reset, !rsp_valid)

endmodule

bind window_gradient_lbp_feature_unit wglf_checker u_wglf_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_if.valid),
   .req_ready         (req_if.ready),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_feature_value (rsp_if.feature_value),
   .rsp_row_end       (rsp_if.row_end),
   .rsp_frame_end     (rsp_if.frame_end)
);

`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 100ps
// Testbench for window_gradient_lbp_feature_unit: directed and random frames, checked in order.
//
// How the checking works:
//  - Every pixel request accepted on the req channel is pushed through a local
//    predictor (two row buffers, a 3x3 neighbourhood and a column/row position).
//    When the pixel completes an interior window, the expected feature, row_end
//    and frame_end go into pending_features.
//  - A separate process pops the oldest expectation on every accepted rsp beat
//    and compares each field; extra beats and wrong fields are counted.
//  - Registers are only rewritten once all pending features have arrived and the
//    pipe has had a few cycles to flush border pixels (they produce no result).
//  - Geometry only grows at a frame boundary, so the row buffers are always
//    written before an emitted window uses them.
module testbench;
   import wglf_pkg::*;

   localparam int RESET_CYCLES = 10;
   localparam int PIPE_SETTLE  = 8;
   localparam int HOLD_CYCLES  = 300;   // long rsp hold-off, enough to back up the input
   localparam int STALL_LIMIT  = 5000;  // cycles without a handshake or register write before giving up
   localparam int PHASE_PIXELS = 160;   // minimum random pixels per traffic phase
   localparam int LINE_DEPTH   = DEFAULT_MAX_ROW_WIDTH;

   typedef struct packed {
      logic [FEATURE_WIDTH-1:0] value;
      logic                     row_end;
      logic                     frame_end;
   } feature_result_type;

   logic                       clock;
   logic                       reset;
   logic                       csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   wglf_req_if req_ch();
   wglf_rsp_if rsp_ch();

   window_gradient_lbp_feature_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   logic [PIXEL_IN_WIDTH-1:0]  upper_row_buf [LINE_DEPTH];
   logic [PIXEL_IN_WIDTH-1:0]  middle_row_buf [LINE_DEPTH];
   logic [PIXEL_IN_WIDTH-1:0]  nbhd [3][3];
   int unsigned                col_pos;
   int unsigned                row_pos;
   feature_mode_type           cfg_mode;
   logic [ROW_WIDTH_BITS-1:0]  cfg_width;
   logic [FRAME_ROWS_BITS-1:0] cfg_rows;
   feature_result_type         pending_features [$];

   // traffic shaping
   int unsigned               send_idle_pct;
   int unsigned               stall_pct;
   bit                        hold_request;
   int                        hold_left;
   logic [PIXEL_IN_WIDTH-1:0] frame_base;

   // bookkeeping
   int mismatch_count;
   int pixels_sent;
   int features_checked;
   int csr_writes;
   int idle_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic clear_predictor;
      foreach (upper_row_buf[i]) begin
         upper_row_buf[i]  = '0;
         middle_row_buf[i] = '0;
      end
      foreach (nbhd[r, c]) nbhd[r][c] = '0;
      col_pos   = 0;
      row_pos   = 0;
      cfg_mode  = MODE_GRADIENT;
      cfg_width = ROW_WIDTH_BITS'(ROW_WIDTH_RESET);
      cfg_rows  = FRAME_ROWS_BITS'(FRAME_ROWS_RESET);
   endtask

   // Shift one pixel into the neighbourhood; queue a feature for interior centres.
   task automatic advance_window(input logic [PIXEL_IN_WIDTH-1:0] pix);
      int unsigned               w;
      int unsigned               h;
      int unsigned               c;
      int                        dx;
      int                        dy;
      int unsigned               mag;
      logic [PIXEL_IN_WIDTH-1:0] ring [8];
      bit                        last_col;
      bit                        last_row;
      feature_result_type        res;
      w = cfg_width;
      if (w < MIN_DIM) w = MIN_DIM;
      if (w > LINE_DEPTH) w = LINE_DEPTH;
      h = cfg_rows;
      if (h < MIN_DIM) h = MIN_DIM;
      if (h > ROWS_LIMIT) h = ROWS_LIMIT;
      c = (col_pos >= LINE_DEPTH) ? LINE_DEPTH - 1 : col_pos;

      for (int k = 0; k < 3; k++) begin
         nbhd[k][0] = nbhd[k][1];
         nbhd[k][1] = nbhd[k][2];
      end
      nbhd[0][2] = upper_row_buf[c];
      nbhd[1][2] = middle_row_buf[c];
      nbhd[2][2] = pix;
      upper_row_buf[c]  = middle_row_buf[c];
      middle_row_buf[c] = pix;

      last_col = (col_pos >= w - 1);
      last_row = (row_pos >= h - 1);

      if (row_pos >= 2 && col_pos >= 2) begin
         if (cfg_mode == MODE_LBP) begin
            // NW, N, NE, W, E, SW, S, SE at weights 2..256; ties set the bit
            ring = '{nbhd[0][0], nbhd[0][1], nbhd[0][2], nbhd[1][0],
                     nbhd[1][2], nbhd[2][0], nbhd[2][1], nbhd[2][2]};
            mag = 0;
            for (int i = 0; i < 8; i++)
               if (nbhd[1][1] >= ring[i]) mag |= (2 << i);
         end else begin
            dx  = int'(nbhd[1][2]) - int'(nbhd[1][0]);
            dy  = int'(nbhd[2][1]) - int'(nbhd[0][1]);
            mag = dx * dx + dy * dy;
            if (mag > FEATURE_MAX) mag = FEATURE_MAX;
         end
         res.value     = mag[FEATURE_WIDTH-1:0];
         res.row_end   = last_col;
         res.frame_end = last_col && last_row;
         pending_features.push_back(res);
      end

      if (last_col) begin
         col_pos = 0;
         row_pos = last_row ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
   endtask

   // Offer one pixel, with random idle cycles ahead of it, and wait for accept.
   task automatic send_pixel(input logic [PIXEL_IN_WIDTH-1:0] pix);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.pixel_value <= pix;
      do begin
         @(posedge clock);
      end while (req_ch.ready !== 1'b1);
      advance_window(pix);
      pixels_sent++;
   endtask

   // One cycle strobe, then the strobe is dropped before returning, so back-to-back writes never collide.
   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_WIDTH-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_FEATURE_MODE: cfg_mode  = feature_mode_type'(data[0]);
         CSR_ROW_WIDTH:    cfg_width = data[ROW_WIDTH_BITS-1:0];
         CSR_FRAME_ROWS:   cfg_rows  = data[FRAME_ROWS_BITS-1:0];
         default: ;
      endcase
      csr_writes++;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_geometry(input int unsigned width_word, input int unsigned rows_word);
      write_csr(CSR_ROW_WIDTH, CSR_DATA_WIDTH'(width_word));
      write_csr(CSR_FRAME_ROWS, CSR_DATA_WIDTH'(rows_word));
   endtask

   // Stop offering, let every queued feature land, then flush border pixels.
   task automatic wait_for_idle;
      req_ch.valid <= 1'b0;
      while (pending_features.size() != 0) @(posedge clock);
      repeat (PIPE_SETTLE) @(posedge clock);
   endtask

   // Mix of extremes, near-ties around a per-frame level, and full-range values.
   function automatic logic [PIXEL_IN_WIDTH-1:0] pick_pixel();
      case ($urandom_range(0, 3))
         0:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
         1:       return frame_base + 8'($urandom_range(0, 2)) - 8'd1;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_random_frame;
      int unsigned               width;
      int unsigned               rows;
      logic [CSR_DATA_WIDTH-1:0] mode_word;
      width     = ($urandom_range(0, 4) == 0) ? $urandom_range(11, 64)
                                               : $urandom_range(MIN_DIM, 10);
      rows      = $urandom_range(MIN_DIM, 6);
      mode_word = CSR_DATA_WIDTH'($urandom);   // only bit 0 matters
      wait_for_idle();
      write_csr(CSR_FEATURE_MODE, mode_word);
      set_geometry(width, rows);
      frame_base = 8'($urandom);
      repeat (width * rows) send_pixel(pick_pixel());
   endtask

   // Gradient mode left at its reset value; full-scale positive and negative differences.
   task automatic test_gradient_extremes;
      logic [PIXEL_IN_WIDTH-1:0] pattern [12];
      pattern = '{8'd5, 8'd0,   8'd255, 8'd9,
                  8'd0, 8'd100, 8'd255, 8'd0,
                  8'd3, 8'd255, 8'd0,   8'd1};
      wait_for_idle();
      set_geometry(4, 3);
      foreach (pattern[i]) send_pixel(pattern[i]);
   endtask

   // LBP: bright centre, dark centre with mixed ring, and a centre tied with neighbours.
   task automatic test_lbp_patterns;
      logic [PIXEL_IN_WIDTH-1:0] pattern [15];
      pattern = '{8'd0, 8'd0,   8'd0, 8'd128, 8'd128,
                  8'd0, 8'd255, 8'd0, 8'd128, 8'd128,
                  8'd0, 8'd0,   8'd0, 8'd128, 8'd128};
      wait_for_idle();
      write_csr(CSR_FEATURE_MODE, CSR_DATA_WIDTH'(MODE_LBP));
      set_geometry(5, 3);
      foreach (pattern[i]) send_pixel(pattern[i]);
   endtask

   // Out-of-range sizes clamp; shrinking mid-frame ends the row / frame at once.
   task automatic test_geometry_clamps;
      wait_for_idle();
      write_csr(CSR_FEATURE_MODE, CSR_DATA_WIDTH'(MODE_GRADIENT));
      set_geometry(6, 13'h1FFF);             // rows clamp to the 4096 limit
      repeat (16) send_pixel(8'($urandom));  // stops at row 2, column 4
      wait_for_idle();
      write_csr(CSR_ROW_WIDTH, '0);          // width 3: column 4 closes the row
      repeat (4) send_pixel(8'($urandom));
      wait_for_idle();
      write_csr(CSR_FRAME_ROWS, '0);         // 3 rows: row 4 closes the frame
      repeat (3) send_pixel(8'($urandom));
   endtask

   task automatic test_random_traffic;
      int phase_start;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 72; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 72; end
            default: begin send_idle_pct = 31; stall_pct = 31; end
         endcase
         phase_start = pixels_sent;
         while (pixels_sent - phase_start < PHASE_PIXELS) send_random_frame();
      end
   endtask

   // Receiver holds off for a long stretch while pixels keep coming, then drain.
   task automatic test_output_backpressure;
      wait_for_idle();
      send_idle_pct = 0;
      stall_pct     = 0;
      write_csr(CSR_FEATURE_MODE, CSR_DATA_WIDTH'($urandom));
      set_geometry(16, 6);
      hold_request <= 1'b1;
      frame_base = 8'($urandom);
      repeat (96) send_pixel(pick_pixel());
      wait_for_idle();
   endtask

   // rsp ready: random stalls, or a counted hold-off when one is requested
   always @(posedge clock) begin
      if (hold_request) begin
         hold_request <= 1'b0;
         hold_left    <= HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left    <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // in-order compare of every accepted feature against the oldest expectation
   always @(posedge clock) begin : check_features
      feature_result_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_features.size() == 0) begin
            $display("%0t: unexpected feature: expected none, got %0d row_end %0b frame_end %0b",
                     $time, rsp_ch.feature_value, rsp_ch.row_end, rsp_ch.frame_end);
            mismatch_count++;
         end else begin
            want = pending_features.pop_front();
            features_checked++;
            if (rsp_ch.feature_value !== want.value) begin
               $display("%0t: feature_value: expected %0d, got %0d",
                        $time, want.value, rsp_ch.feature_value);
               mismatch_count++;
            end
            if (rsp_ch.row_end !== want.row_end) begin
               $display("%0t: row_end: expected %0b, got %0b",
                        $time, want.row_end, rsp_ch.row_end);
               mismatch_count++;
            end
            if (rsp_ch.frame_end !== want.frame_end) begin
               $display("%0t: frame_end: expected %0b, got %0b",
                        $time, want.frame_end, rsp_ch.frame_end);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog: any handshake or register write counts as progress
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || csr_we)
      begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles, %0d features outstanding",
                  $time, idle_cycles, pending_features.size());
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = CSR_FEATURE_MODE;
      csr_wdata          = '0;
      req_ch.valid       = 1'b0;
      req_ch.pixel_value = '0;
      rsp_ch.ready       = 1'b0;
      hold_request       = 1'b0;
      hold_left          = 0;
      send_idle_pct      = 0;
      stall_pct          = 0;
      frame_base         = '0;
      clear_predictor();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_gradient_extremes();
      test_lbp_patterns();
      test_geometry_clamps();
      test_random_traffic();
      test_output_backpressure();

      wait_for_idle();
      repeat (20) @(posedge clock);
      $display("Run covered %0d pixel requests, %0d features checked, %0d register writes:",
               pixels_sent, features_checked, csr_writes);
      $display("both modes, clamped and shrunken sizes, idle and stall mixes, and a long hold.");
      if (pending_features.size() != 0)
         $display("%0d expected features never arrived", pending_features.size());
      if (mismatch_count == 0 && pending_features.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

>>> window_gradient_lbp_feature_unit.f
+incdir+sv
sv/wglf_pkg.sv
sv/wglf_if.sv
sv/window_gradient_lbp_feature_unit.sv
sv/wglf_checker.sv
sim/testbench.sv
